// ===== hdl/utf8cp_pkg.sv =====
// Shared constants and types for the UTF-8 to Cyrillic code page unit.
package utf8cp_pkg;

  localparam int KindW = 3;

  // Pending sequence kinds
  localparam logic [KindW-1:0] KIND_NONE    = 3'd0;
  localparam logic [KindW-1:0] KIND_D0      = 3'd1;
  localparam logic [KindW-1:0] KIND_D1      = 3'd2;
  localparam logic [KindW-1:0] KIND_E2_MID  = 3'd3;
  localparam logic [KindW-1:0] KIND_E2_LAST = 3'd4;

  // Output code page selection
  localparam logic TARGET_CP866 = 1'b0;
  localparam logic TARGET_1251  = 1'b1;

  // UTF-8 lead and continuation bytes of interest
  localparam logic [7:0] LEAD_D0    = 8'd208;
  localparam logic [7:0] LEAD_D1    = 8'd209;
  localparam logic [7:0] LEAD_E2    = 8'd226;
  localparam logic [7:0] D0_LO      = 8'd144;
  localparam logic [7:0] D0_HI      = 8'd191;
  localparam logic [7:0] D0_YO      = 8'd129;
  localparam logic [7:0] D1_LO      = 8'd128;
  localparam logic [7:0] D1_HI      = 8'd143;
  localparam logic [7:0] D1_YO      = 8'd145;
  localparam logic [7:0] E2_NUMERO  = 8'd150;

  // Offsets and fixed codes
  localparam logic [7:0] D0_DOWN_866  = 8'd16;
  localparam logic [7:0] D0_UP_1251   = 8'd48;
  localparam logic [7:0] D1_UP_866    = 8'd96;
  localparam logic [7:0] D1_UP_1251   = 8'd112;
  localparam logic [7:0] YO_UP_866    = 8'd240;
  localparam logic [7:0] YO_UP_1251   = 8'd168;
  localparam logic [7:0] YO_LO_866    = 8'd241;
  localparam logic [7:0] YO_LO_1251   = 8'd184;
  localparam logic [7:0] NUMERO_866   = 8'd252;
  localparam logic [7:0] NUMERO_1251  = 8'd185;

  typedef struct packed {
    logic             emit;
    logic [7:0]       code;
    logic [KindW-1:0] kind_next;
  } map_res_t;

endpackage

// ===== hdl/utf8_to_cyrillic_codepage_unit.sv =====
// Top level: UTF-8 byte stream to CP866 or Windows-1251 single-byte codes.
// Takes one byte per clock cycle while in_stall is low. Each byte is captured
// in an input register, decoded against the pending lead-byte state in one
// pass of logic, and the code lands in the result register. Lead bytes and
// the middle byte of a three-byte sequence give no result and leave the
// input register at once, even while the result register is stalled.
// target_code selects the code page (0 CP866, 1 Windows-1251) and is stored
// on target_code_we; the stored value is read when a result is formed.
module utf8_to_cyrillic_codepage_unit
  import utf8cp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       target_code_we,
  input  logic       target_code,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte
);

  logic             target_reg;
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic [KindW-1:0] kind;
  map_res_t         res;
  logic             out_free;
  logic             s1_advance;
  logic             in_take;

  utf8cp_map u_map (
    .kind        (kind),
    .in_byte     (s1_byte),
    .target_code (target_reg),
    .res         (res)
  );

  assign out_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && (out_free || !res.emit);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_reg <= TARGET_CP866;
    end else if (target_code_we) begin
      target_reg <= target_code;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= in_byte;
    end
  end

  // pending state advances with every byte leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_NONE;
    end else if (s1_advance) begin
      kind <= res.kind_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && res.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && res.emit) begin
      out_byte <= res.code;
    end
  end

endmodule

// ===== hdl/utf8cp_map.sv =====
// Per-byte decode: pending kind and byte in, result byte and next kind out.
module utf8cp_map
  import utf8cp_pkg::*;
(
  input  logic [KindW-1:0] kind,
  input  logic [7:0]       in_byte,
  input  logic             target_code,
  output map_res_t         res
);

  logic win;
  assign win = (target_code == TARGET_1251);

  always_comb begin
    res.emit      = 1'b1;
    res.code      = in_byte;
    res.kind_next = KIND_NONE;
    unique case (kind)
      KIND_D0: begin
        if (in_byte >= D0_LO && in_byte <= D0_HI) begin
          res.code = win ? 8'(in_byte + D0_UP_1251) : 8'(in_byte - D0_DOWN_866);
        end else if (in_byte == D0_YO) begin
          res.code = win ? YO_UP_1251 : YO_UP_866;
        end
      end
      KIND_D1: begin
        if (in_byte >= D1_LO && in_byte <= D1_HI) begin
          res.code = win ? 8'(in_byte + D1_UP_1251) : 8'(in_byte + D1_UP_866);
        end else if (in_byte == D1_YO) begin
          res.code = win ? YO_LO_1251 : YO_LO_866;
        end
      end
      KIND_E2_MID: begin
        // skip the middle byte unchecked
        res.emit      = 1'b0;
        res.kind_next = KIND_E2_LAST;
      end
      KIND_E2_LAST: begin
        if (in_byte == E2_NUMERO) begin
          res.code = win ? NUMERO_1251 : NUMERO_866;
        end
      end
      default: begin
        // nothing pending: a lead byte opens a sequence, anything else passes
        if (in_byte == LEAD_D0) begin
          res.emit      = 1'b0;
          res.kind_next = KIND_D0;
        end else if (in_byte == LEAD_D1) begin
          res.emit      = 1'b0;
          res.kind_next = KIND_D1;
        end else if (in_byte == LEAD_E2) begin
          res.emit      = 1'b0;
          res.kind_next = KIND_E2_MID;
        end
      end
    endcase
  end

endmodule

// ===== bench/tb.sv =====
// Testbench for the UTF-8 to Cyrillic code page unit: predicted codes against DUT output.
module tb;
  import utf8cp_pkg::*;

  localparam int QuietLimit = 1000;
  localparam int DrainCycles = 4;

  // Tracks the pending lead state and queues the code each emitting transfer should produce.
  class cyrillic_scoreboard;
    logic [7:0]       expected_codes[$];
    logic [KindW-1:0] pending;
    logic             use_1251;
    int               errors;

    function new();
      pending  = KIND_NONE;
      use_1251 = TARGET_CP866;
      errors   = 0;
    endfunction

    function void set_target(logic t);
      use_1251 = t;
    endfunction

    function void take_byte(logic [7:0] b);
      logic [7:0] code;
      bit         emit;
      code = b;
      emit = 1'b1;
      case (pending)
        KIND_D0: begin
          pending = KIND_NONE;
          if (b >= D0_LO && b <= D0_HI) begin
            code = use_1251 ? b + D0_UP_1251 : b - D0_DOWN_866;
          end else if (b == D0_YO) begin
            code = use_1251 ? YO_UP_1251 : YO_UP_866;
          end
        end
        KIND_D1: begin
          pending = KIND_NONE;
          if (b >= D1_LO && b <= D1_HI) begin
            code = use_1251 ? b + D1_UP_1251 : b + D1_UP_866;
          end else if (b == D1_YO) begin
            code = use_1251 ? YO_LO_1251 : YO_LO_866;
          end
        end
        KIND_E2_MID: begin
          // skip the middle byte unchecked
          pending = KIND_E2_LAST;
          emit = 1'b0;
        end
        KIND_E2_LAST: begin
          pending = KIND_NONE;
          if (b == E2_NUMERO) code = use_1251 ? NUMERO_1251 : NUMERO_866;
        end
        default: begin
          pending = KIND_NONE;
          if (b == LEAD_D0) begin
            pending = KIND_D0;
            emit = 1'b0;
          end else if (b == LEAD_D1) begin
            pending = KIND_D1;
            emit = 1'b0;
          end else if (b == LEAD_E2) begin
            pending = KIND_E2_MID;
            emit = 1'b0;
          end
        end
      endcase
      if (emit) expected_codes.push_back(code);
    endfunction

    function void check_code(logic [7:0] got);
      logic [7:0] want;
      if (expected_codes.size() == 0) begin
        $display("%0t: out_byte expected none, got %0d", $time, got);
        errors++;
      end else begin
        want = expected_codes.pop_front();
        if (got !== want) begin
          $display("%0t: out_byte expected %0d, got %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       target_code_we = 1'b0;
  logic       target_code = TARGET_CP866;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;

  int in_idle_pct = 15;
  int out_idle_pct = 50;
  int quiet = 0;

  cyrillic_scoreboard sb = new();

  utf8_to_cyrillic_codepage_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .target_code_we (target_code_we),
    .target_code    (target_code),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte)
  );

  always #2 clk = ~clk;

  // Check each output transfer, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_code(out_byte);
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b);
  endtask

  task automatic write_target(input logic t);
    target_code_we <= 1'b1;
    target_code    <= t;
    @(posedge clk);
    target_code_we <= 1'b0;
    sb.set_target(t);
  endtask

  // Hold off until every expected code is out and the input stage is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_codes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic run_directed();
    logic [7:0] seq[$];
    seq = '{8'd0, 8'd255,
            LEAD_D0, D0_LO, LEAD_D0, D0_HI, LEAD_D0, D0_YO,
            LEAD_D1, D1_LO, LEAD_D1, D1_HI, LEAD_D1, D1_YO,
            LEAD_E2, 8'd0, E2_NUMERO,
            LEAD_D0, LEAD_D0, LEAD_D1, LEAD_E2,
            LEAD_E2, LEAD_D0, LEAD_D1,
            LEAD_D0, 8'd0};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Mostly well-formed Cyrillic pairs and numero triples; the rest is ASCII and noise.
  task automatic run_random(input int n_items);
    int sent;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_byte(LEAD_D0);
        case ($urandom_range(3))
          0, 1: send_byte(8'($urandom_range(D0_HI, D0_LO)));
          2: send_byte(D0_YO);
          default: send_byte(8'($urandom));
        endcase
        sent += 2;
      end else if (pick < 60) begin
        send_byte(LEAD_D1);
        case ($urandom_range(3))
          0, 1: send_byte(8'($urandom_range(D1_HI, D1_LO)));
          2: send_byte(D1_YO);
          default: send_byte(8'($urandom));
        endcase
        sent += 2;
      end else if (pick < 72) begin
        send_byte(LEAD_E2);
        send_byte(8'($urandom));
        send_byte($urandom_range(1) ? E2_NUMERO : 8'($urandom));
        sent += 3;
      end else if (pick < 85) begin
        send_byte(8'($urandom_range(127)));
        sent++;
      end else begin
        send_byte(8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    in_idle_pct  = 15;
    out_idle_pct = 50;
    write_target(TARGET_CP866);
    run_directed();
    settle();
    write_target(TARGET_1251);
    run_random(550);
    settle();

    in_idle_pct  = 50;
    out_idle_pct = 15;
    write_target(TARGET_CP866);
    run_random(550);
    settle();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_target(TARGET_1251);
    run_random(550);
    settle();

    if (sb.errors == 0 && sb.expected_codes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== utf8_to_cyrillic_codepage_unit.f =====
hdl/utf8cp_pkg.sv
hdl/utf8cp_map.sv
hdl/utf8_to_cyrillic_codepage_unit.sv
bench/tb.sv
